### rtl/core/single_button_menu_fsm_unit_macros.svh
// Assertion helpers for the menu controller.
`ifndef SINGLE_BUTTON_MENU_FSM_UNIT_MACROS_SVH
`define SINGLE_BUTTON_MENU_FSM_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SMBF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("menu controller assertion failed");
`define SMBF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("menu controller reset assertion failed");
`else
`define SMBF_ASSERT(lbl, clk, rst_n, prop)
`define SMBF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/core/smbf_pkg.sv
package smbf_pkg;

    typedef enum logic [2:0] {
        M_MON        = 3'd0,
        M_MAIN       = 3'd1,
        M_CONFIG     = 3'd2,
        M_RESET_ASK  = 3'd3,
        M_RESET_RES  = 3'd4,
        M_REBOOT_ASK = 3'd5,
        M_COUNTDOWN  = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        CFG_REFRESH_INTERVAL = 2'd0,
        CFG_AUTO_RETURN      = 2'd1,
        CFG_COUNTDOWN_SECS   = 2'd2
    } t_cfg_index;

    localparam logic [15:0] REFRESH_INTERVAL_RST = 16'd1000;
    localparam logic [15:0] AUTO_RETURN_RST      = 16'd3000;
    localparam logic [3:0]  COUNTDOWN_SECS_RST   = 4'd3;
    localparam logic [10:0] MS_PER_SECOND        = 11'd1000;
    localparam logic [15:0] MS_MAX               = 16'hFFFF;

    typedef struct packed {
        logic [15:0] refresh_interval_ms;
        logic [15:0] auto_return_ms;
        logic [3:0]  countdown_seconds;
    } t_cfg;

    typedef struct packed {
        logic short_press;
        logic long_press;
        logic reset_ok;
    } t_item;

    typedef struct packed {
        t_mode       mode;
        logic [1:0]  cursor;
        logic [1:0]  page;
        logic        web_enabled;
        logic        reset_outcome;
        logic [3:0]  countdown_left;
        logic [9:0]  frac_ms;
        logic [15:0] result_ms;
        logic [15:0] refresh_ms;
        logic        draw_pending;
    } t_state;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] cursor;
        logic [1:0] page;
        logic [3:0] seconds_left;
        logic       web_on;
        logic       reset_shown;
        logic       redraw;
        logic       web_toggle;
        logic       reset_request;
        logic       reboot;
    } t_result;

    function automatic t_state reset_state();
        t_state s;
        s.mode           = M_MON;
        s.cursor         = 2'd0;
        s.page           = 2'd0;
        s.web_enabled    = 1'b0;
        s.reset_outcome  = 1'b0;
        s.countdown_left = 4'd0;
        s.frac_ms        = 10'd0;
        s.result_ms      = 16'd0;
        s.refresh_ms     = 16'd0;
        s.draw_pending   = 1'b1;
        return s;
    endfunction

endpackage

### rtl/core/smbf_cfg_regs.sv
module smbf_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output smbf_pkg::t_cfg    o_cfg
);
    import smbf_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.refresh_interval_ms <= REFRESH_INTERVAL_RST;
            r_cfg.auto_return_ms      <= AUTO_RETURN_RST;
            r_cfg.countdown_seconds   <= COUNTDOWN_SECS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_REFRESH_INTERVAL: r_cfg.refresh_interval_ms <= i_cfg_data;
                CFG_AUTO_RETURN:      r_cfg.auto_return_ms      <= i_cfg_data;
                CFG_COUNTDOWN_SECS:   r_cfg.countdown_seconds   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

endmodule

### rtl/core/smbf_step.sv
module smbf_step (
    input  smbf_pkg::t_cfg    i_cfg,
    input  smbf_pkg::t_state  i_state,
    input  smbf_pkg::t_item   i_item,
    output smbf_pkg::t_state  o_state,
    output smbf_pkg::t_result o_result
);
    import smbf_pkg::*;

    always_comb begin
        t_state      s;
        logic [10:0] frac_sum;
        logic        redraw;
        logic        toggle;
        logic        rst_req;
        logic        reboot;

        s              = i_state;
        redraw         = s.draw_pending;
        s.draw_pending = 1'b0;
        toggle         = 1'b0;
        rst_req        = 1'b0;
        reboot         = 1'b0;

        // millisecond timers
        if (s.refresh_ms != MS_MAX) s.refresh_ms = s.refresh_ms + 16'd1;
        if (s.mode == M_RESET_RES && s.result_ms != MS_MAX) begin
            s.result_ms = s.result_ms + 16'd1;
        end
        frac_sum = {1'b0, s.frac_ms} + 11'd1;
        if (s.mode == M_COUNTDOWN) begin
            if (frac_sum >= MS_PER_SECOND) begin
                s.frac_ms = 10'd0;
                if (s.countdown_left != 4'd0) s.countdown_left = s.countdown_left - 4'd1;
                redraw = 1'b1;
            end else begin
                s.frac_ms = frac_sum[9:0];
            end
        end

        if (i_item.short_press) begin
            case (s.mode)
                M_MON: begin
                    case (s.page)
                        2'd0:    s.page = 2'd1;
                        2'd1:    s.page = 2'd2;
                        2'd2:    s.page = 2'd0;
                        default: s.page = 2'd1;
                    endcase
                end
                M_MAIN:  s.cursor = s.cursor + 2'd1;
                M_CONFIG, M_RESET_ASK, M_REBOOT_ASK: s.cursor = {1'b0, ~s.cursor[0]};
                default: ;
            endcase
            redraw = 1'b1;
        end

        if (i_item.long_press) begin
            case (s.mode)
                M_MON: begin
                    s.mode   = M_MAIN;
                    s.cursor = 2'd0;
                end
                M_MAIN: begin
                    case (s.cursor)
                        2'd0:    s.mode = M_CONFIG;
                        2'd1:    s.mode = M_RESET_ASK;
                        2'd2:    s.mode = M_REBOOT_ASK;
                        default: begin
                            s.mode = M_MON;
                            s.page = 2'd0;
                        end
                    endcase
                    if (s.cursor != 2'd3) s.cursor = 2'd0;
                end
                M_CONFIG: begin
                    if (s.cursor == 2'd0) begin
                        s.web_enabled = ~s.web_enabled;
                        toggle        = 1'b1;
                    end else begin
                        s.mode   = M_MAIN;
                        s.cursor = 2'd0;
                    end
                end
                M_RESET_ASK: begin
                    if (s.cursor == 2'd0) begin
                        s.reset_outcome = i_item.reset_ok;
                        rst_req         = 1'b1;
                        s.mode          = M_RESET_RES;
                        s.result_ms     = 16'd0;
                    end else begin
                        s.mode   = M_MAIN;
                        s.cursor = 2'd0;
                    end
                end
                M_REBOOT_ASK: begin
                    if (s.cursor == 2'd0) begin
                        s.mode           = M_COUNTDOWN;
                        s.countdown_left = i_cfg.countdown_seconds;
                        s.frac_ms        = 10'd0;
                    end else begin
                        s.mode   = M_MAIN;
                        s.cursor = 2'd0;
                    end
                end
                M_RESET_RES: begin
                    s.mode   = M_MAIN;
                    s.cursor = 2'd0;
                end
                default: ;
            endcase
            redraw = 1'b1;
        end

        // automatic transitions
        if (s.mode == M_RESET_RES) begin
            if (s.result_ms >= i_cfg.auto_return_ms) begin
                s.mode   = M_MAIN;
                s.cursor = 2'd0;
                redraw   = 1'b1;
            end
        end else if (s.mode == M_COUNTDOWN) begin
            if (s.countdown_left == 4'd0) begin
                reboot         = 1'b1;
                s              = reset_state();
                s.draw_pending = 1'b0;
                redraw         = 1'b1;
            end
        end

        if (s.mode == M_MON && s.refresh_ms >= i_cfg.refresh_interval_ms) begin
            s.refresh_ms = 16'd0;
            redraw       = 1'b1;
        end

        o_state                = s;
        o_result.mode          = s.mode;
        o_result.cursor        = (s.mode == M_MAIN || s.mode == M_CONFIG ||
                                  s.mode == M_RESET_ASK || s.mode == M_REBOOT_ASK)
                                 ? s.cursor : 2'd0;
        o_result.page          = s.page;
        o_result.seconds_left  = (s.mode == M_COUNTDOWN) ? s.countdown_left : 4'd0;
        o_result.web_on        = s.web_enabled;
        o_result.reset_shown   = s.reset_outcome;
        o_result.redraw        = redraw;
        o_result.web_toggle    = toggle;
        o_result.reset_request = rst_req;
        o_result.reboot        = reboot;
    end

endmodule

### rtl/core/single_button_menu_fsm_unit.sv
// Single-button menu controller. Each accepted item is one millisecond tick carrying the
// short/long press flags and the energy-reset outcome; each item yields exactly one result
// item with the visible mode, cursor, page, countdown, web and reset state plus redraw and
// the web-toggle, reset-request and reboot pulses. One item per cycle is sustained while the
// result side does not stall; an accepted item goes through the input register, one pass of
// step logic against the state register, and the result register, and a stalled result holds
// the input side for as long as the stall lasts. No clearing pass after reset. Configuration
// writes are always ready and take effect on items accepted afterwards.
`include "single_button_menu_fsm_unit_macros.svh"

module single_button_menu_fsm_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_short_press,
    input  logic        i_long_press,
    input  logic        i_reset_ok,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_mode,
    output logic [1:0]  o_cursor,
    output logic [1:0]  o_page,
    output logic [3:0]  o_seconds_left,
    output logic        o_web_on,
    output logic        o_reset_shown,
    output logic        o_redraw,
    output logic        o_web_toggle,
    output logic        o_reset_request,
    output logic        o_reboot,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import smbf_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_state  r_state;
    t_state  n_state;
    t_result n_out;
    t_result r_out;
    logic    r_out_valid;
    logic    advance;
    logic    step_fire;

    smbf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    smbf_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign advance   = !r_out_valid || !i_stall;
    assign step_fire = r_in_valid && advance;
    assign o_stall   = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in.short_press <= i_short_press;
            r_in.long_press  <= i_long_press;
            r_in.reset_ok    <= i_reset_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= reset_state();
        end else if (step_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_out <= n_out;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_mode          = r_out.mode;
    assign o_cursor        = r_out.cursor;
    assign o_page          = r_out.page;
    assign o_seconds_left  = r_out.seconds_left;
    assign o_web_on        = r_out.web_on;
    assign o_reset_shown   = r_out.reset_shown;
    assign o_redraw        = r_out.redraw;
    assign o_web_toggle    = r_out.web_toggle;
    assign o_reset_request = r_out.reset_request;
    assign o_reboot        = r_out.reboot;

    `SMBF_ASSERT(a_backpressure, i_clk, i_rst_n,
        (r_in_valid && o_valid && i_stall) |-> o_stall)
    `SMBF_ASSERT(a_reboot_clears, i_clk, i_rst_n,
        (o_valid && o_reboot) |-> (o_mode == M_MON && o_redraw && !o_web_on && o_page == 2'd0))
    `SMBF_ASSERT(a_toggle_in_config, i_clk, i_rst_n,
        (o_valid && o_web_toggle) |-> (o_mode == M_CONFIG && o_cursor == 2'd0))
    `SMBF_ASSERT(a_reset_goes_result, i_clk, i_rst_n,
        (o_valid && o_reset_request) |-> (o_mode == M_RESET_RES || o_mode == M_MAIN))
    `SMBF_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!o_valid && !o_stall))

endmodule

### dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smbf_pkg::*;

    localparam int STUCK_LIMIT = 500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_short_press = 1'b0;
    logic        i_long_press = 1'b0;
    logic        i_reset_ok = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_mode;
    logic [1:0]  o_cursor;
    logic [1:0]  o_page;
    logic [3:0]  o_seconds_left;
    logic        o_web_on;
    logic        o_reset_shown;
    logic        o_redraw;
    logic        o_web_toggle;
    logic        o_reset_request;
    logic        o_reboot;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [15:0] i_cfg_data = 16'd0;

    single_button_menu_fsm_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_short_press   (i_short_press),
        .i_long_press    (i_long_press),
        .i_reset_ok      (i_reset_ok),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_mode          (o_mode),
        .o_cursor        (o_cursor),
        .o_page          (o_page),
        .o_seconds_left  (o_seconds_left),
        .o_web_on        (o_web_on),
        .o_reset_shown   (o_reset_shown),
        .o_redraw        (o_redraw),
        .o_web_toggle    (o_web_toggle),
        .o_reset_request (o_reset_request),
        .o_reboot        (o_reboot),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    t_state      menu;
    logic [15:0] cfg_refresh_ms;
    logic [15:0] cfg_return_ms;
    logic [3:0]  cfg_countdown_s;
    t_result     expected_screens[$];

    bit feed_steady = 1'b0;
    bit drain_steady = 1'b0;
    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;
    int resets_seen = 0;
    int reboots_seen = 0;
    int stuck_cycles = 0;
    int hold_cycles = 0;

    task automatic clear_menu();
        menu.mode           = M_MON;
        menu.cursor         = 2'd0;
        menu.page           = 2'd0;
        menu.web_enabled    = 1'b0;
        menu.reset_outcome  = 1'b0;
        menu.countdown_left = 4'd0;
        menu.frac_ms        = 10'd0;
        menu.result_ms      = 16'd0;
        menu.refresh_ms     = 16'd0;
        menu.draw_pending   = 1'b1;
    endtask

    task automatic enter_mode(input t_mode m);
        menu.mode   = m;
        menu.cursor = 2'd0;
    endtask

    // one millisecond of menu behavior
    task automatic tick_menu(input logic sp, input logic lp, input logic ok,
                             output t_result r);
        logic redraw;
        logic toggle;
        logic rst_pulse;
        logic reboot_pulse;
        redraw       = menu.draw_pending;
        toggle       = 1'b0;
        rst_pulse    = 1'b0;
        reboot_pulse = 1'b0;
        menu.draw_pending = 1'b0;

        if (menu.refresh_ms != MS_MAX) menu.refresh_ms++;
        if (menu.mode == M_RESET_RES && menu.result_ms != MS_MAX) menu.result_ms++;
        if (menu.mode == M_COUNTDOWN) begin
            menu.frac_ms++;
            if (menu.frac_ms >= MS_PER_SECOND) begin
                menu.frac_ms = 10'd0;
                if (menu.countdown_left != 4'd0) menu.countdown_left--;
                redraw = 1'b1;
            end
        end

        if (sp) begin
            case (menu.mode)
                M_MON: menu.page = (menu.page == 2'd2) ? 2'd0 : menu.page + 2'd1;
                M_MAIN: menu.cursor = menu.cursor + 2'd1;
                M_CONFIG, M_RESET_ASK, M_REBOOT_ASK: menu.cursor = {1'b0, ~menu.cursor[0]};
                default: ;
            endcase
            redraw = 1'b1;
        end

        if (lp) begin
            case (menu.mode)
                M_MON: enter_mode(M_MAIN);
                M_MAIN: begin
                    case (menu.cursor)
                        2'd0: enter_mode(M_CONFIG);
                        2'd1: enter_mode(M_RESET_ASK);
                        2'd2: enter_mode(M_REBOOT_ASK);
                        default: begin
                            menu.mode = M_MON;
                            menu.page = 2'd0;
                        end
                    endcase
                end
                M_CONFIG: begin
                    if (menu.cursor == 2'd0) begin
                        menu.web_enabled = ~menu.web_enabled;
                        toggle = 1'b1;
                    end else begin
                        enter_mode(M_MAIN);
                    end
                end
                M_RESET_ASK: begin
                    if (menu.cursor == 2'd0) begin
                        menu.reset_outcome = ok;
                        rst_pulse = 1'b1;
                        menu.mode = M_RESET_RES;
                        menu.result_ms = 16'd0;
                    end else begin
                        enter_mode(M_MAIN);
                    end
                end
                M_REBOOT_ASK: begin
                    if (menu.cursor == 2'd0) begin
                        menu.mode = M_COUNTDOWN;
                        menu.countdown_left = cfg_countdown_s;
                        menu.frac_ms = 10'd0;
                    end else begin
                        enter_mode(M_MAIN);
                    end
                end
                M_RESET_RES: enter_mode(M_MAIN);
                default: ;
            endcase
            redraw = 1'b1;
        end

        if (menu.mode == M_RESET_RES) begin
            if (menu.result_ms >= cfg_return_ms) begin
                enter_mode(M_MAIN);
                redraw = 1'b1;
            end
        end else if (menu.mode == M_COUNTDOWN) begin
            if (menu.countdown_left == 4'd0) begin
                reboot_pulse = 1'b1;
                clear_menu();
                menu.draw_pending = 1'b0;
                redraw = 1'b1;
            end
        end

        if (menu.mode == M_MON && menu.refresh_ms >= cfg_refresh_ms) begin
            menu.refresh_ms = 16'd0;
            redraw = 1'b1;
        end

        r.mode = menu.mode;
        r.cursor = (menu.mode inside {M_MAIN, M_CONFIG, M_RESET_ASK, M_REBOOT_ASK})
                   ? menu.cursor : 2'd0;
        r.page = menu.page;
        r.seconds_left = (menu.mode == M_COUNTDOWN) ? menu.countdown_left : 4'd0;
        r.web_on = menu.web_enabled;
        r.reset_shown = menu.reset_outcome;
        r.redraw = redraw;
        r.web_toggle = toggle;
        r.reset_request = rst_pulse;
        r.reboot = reboot_pulse;
        if (rst_pulse) resets_seen++;
        if (reboot_pulse) reboots_seen++;
    endtask

    task automatic send_item(input logic sp, input logic lp, input logic ok);
        int gap;
        t_result r;
        gap = feed_steady ? 0 : $urandom_range(9);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_short_press <= sp;
        i_long_press  <= lp;
        i_reset_ok    <= ok;
        do @(posedge i_clk); while (o_stall);
        tick_menu(sp, lp, ok, r);
        expected_screens.push_back(r);
        items_sent++;
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_REFRESH_INTERVAL: cfg_refresh_ms = value;
            CFG_AUTO_RETURN:      cfg_return_ms = value;
            CFG_COUNTDOWN_SECS:   cfg_countdown_s = value[3:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [15:0] refresh, input logic [15:0] ret,
                                input logic [3:0] secs);
        i_valid <= 1'b0;
        while (expected_screens.size() != 0) @(posedge i_clk);
        write_reg(CFG_REFRESH_INTERVAL, refresh);
        write_reg(CFG_AUTO_RETURN, ret);
        write_reg(CFG_COUNTDOWN_SECS, {12'd0, secs});
        i_cfg_valid <= 1'b0;
    endtask

    // press through the menus until the given confirm screen shows its first line
    task automatic steer_to_confirm(input t_mode target);
        logic [1:0] line;
        logic sp;
        logic lp;
        line = (target == M_RESET_ASK) ? 2'd1 : 2'd2;
        while (!(menu.mode == target && menu.cursor == 2'd0)) begin
            sp = 1'b0;
            lp = 1'b0;
            case (menu.mode)
                M_MON, M_RESET_RES: lp = 1'b1;
                M_MAIN: if (menu.cursor == line) lp = 1'b1; else sp = 1'b1;
                M_COUNTDOWN: ;
                default: begin
                    if (menu.mode == target || menu.cursor == 2'd0) sp = 1'b1;
                    else lp = 1'b1;
                end
            endcase
            send_item(sp, lp, 1'($urandom_range(1)));
        end
    endtask

    task automatic random_items(input int n);
        logic sp;
        logic lp;
        for (int k = 0; k < n; k++) begin
            if (k % 50 == 0) begin
                feed_steady  = ($urandom_range(3) == 0);
                drain_steady = ($urandom_range(3) == 0);
            end
            sp = ($urandom_range(99) < 25);
            lp = ($urandom_range(99) < 18);
            // only a zero-second countdown may be started here
            if (lp && menu.mode == M_REBOOT_ASK && (menu.cursor[0] == sp)
                    && cfg_countdown_s != 4'd0)
                lp = 1'b0;
            send_item(sp, lp, 1'($urandom_range(1)));
        end
    endtask

    task automatic test_power_on();
        random_items(130);
    endtask

    task automatic test_directed_walk();
        feed_steady  = 1'b0;
        drain_steady = 1'b0;
        program_regs(16'd0, 16'd0, 4'd0);
        repeat (3) send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b0, 1'b1, 1'b0);
        repeat (4) send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b0, 1'b1, 1'b0);
        send_item(1'b0, 1'b1, 1'b0);
        send_item(1'b1, 1'b1, 1'b0);
        send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b0, 1'b1, 1'b0);
        send_item(1'b1, 1'b0, 1'b1);
        send_item(1'b1, 1'b1, 1'b1);
        repeat (2) send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b0, 1'b1, 1'b0);
        send_item(1'b0, 1'b1, 1'b1);
        send_item(1'b0, 1'b1, 1'b0);
        repeat (3) send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_result_timeout();
        program_regs(16'd7, 16'd5, 4'd0);
        steer_to_confirm(M_RESET_ASK);
        send_item(1'b0, 1'b1, 1'b1);
        while (menu.mode == M_RESET_RES) send_item(1'b0, 1'b0, 1'b0);
        steer_to_confirm(M_RESET_ASK);
        send_item(1'b0, 1'b1, 1'b0);
        send_item(1'b1, 1'b0, 1'b1);
        send_item(1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_countdown_expiry();
        int k;
        k = 0;
        program_regs(16'($urandom_range(1, 50)), 16'd20, 4'd1);
        steer_to_confirm(M_REBOOT_ASK);
        send_item(1'b0, 1'b1, 1'($urandom_range(1)));
        while (menu.mode == M_COUNTDOWN) begin
            if (k % 100 == 0) begin
                feed_steady  = ($urandom_range(1) == 0);
                drain_steady = ($urandom_range(1) == 0);
            end
            send_item(1'($urandom_range(19) == 0), 1'($urandom_range(19) == 0),
                      1'($urandom_range(1)));
            k++;
        end
    endtask

    task automatic test_random_settings();
        program_regs(16'd0, 16'd0, 4'd0);
        random_items(70);
        program_regs(16'hFFFF, 16'hFFFF, 4'hF);
        random_items(70);
        program_regs(16'd1, 16'd1, 4'd0);
        random_items(70);
        program_regs(16'($urandom_range(2, 200)), 16'($urandom_range(2, 60)), 4'd0);
        random_items(70);
        program_regs(16'($urandom_range(1, 2000)), 16'($urandom_range(0, 400)),
                     4'($urandom_range(2, 14)));
        random_items(70);
    endtask

    // ends the run inside a maximum-length countdown
    task automatic test_countdown_load();
        program_regs(16'd1, 16'hFFFF, 4'hF);
        steer_to_confirm(M_REBOOT_ASK);
        send_item(1'b0, 1'b1, 1'b0);
        repeat (20) send_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
    endtask

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (!i_rst_n) begin
            hold_cycles = 0;
        end else if (o_valid && !i_stall) begin
            if (expected_screens.size() == 0) begin
                $error("result item with no pending expectation");
                mismatches++;
            end else begin
                want = expected_screens.pop_front();
                compare_field("mode", want.mode, o_mode);
                compare_field("cursor", want.cursor, o_cursor);
                compare_field("page", want.page, o_page);
                compare_field("seconds_left", want.seconds_left, o_seconds_left);
                compare_field("web_on", want.web_on, o_web_on);
                compare_field("reset_shown", want.reset_shown, o_reset_shown);
                compare_field("redraw", want.redraw, o_redraw);
                compare_field("web_toggle", want.web_toggle, o_web_toggle);
                compare_field("reset_request", want.reset_request, o_reset_request);
                compare_field("reboot", want.reboot, o_reboot);
                results_checked++;
            end
            hold_cycles = drain_steady ? 0 : $urandom_range(9);
        end else if (hold_cycles > 0) begin
            hold_cycles--;
        end
        i_stall <= (hold_cycles > 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("no handshake for %0d cycles, %0d results outstanding",
                         stuck_cycles, expected_screens.size());
                $display("single_button_menu_fsm_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        cfg_refresh_ms  = REFRESH_INTERVAL_RST;
        cfg_return_ms   = AUTO_RETURN_RST;
        cfg_countdown_s = COUNTDOWN_SECS_RST;
        clear_menu();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_power_on();
        test_directed_walk();
        test_result_timeout();
        test_countdown_expiry();
        test_random_settings();
        test_countdown_load();

        i_valid <= 1'b0;
        while (expected_screens.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        $display("%0d items sent, %0d results checked; %0d energy resets, %0d reboots",
                 items_sent, results_checked, resets_seen, reboots_seen);
        if (mismatches == 0)
            $display("single_button_menu_fsm_unit verification clean");
        else
            $display("single_button_menu_fsm_unit verification failed");
        $finish;
    end
endmodule
